@@ sv/hpg_pkg.sv @@
package hpg_pkg;

    localparam int GAM_FRAC_BITS_DEF = 16;
    localparam int GAM_FRAC_BITS_MAX = 16;
    localparam int GAM_LEVELS        = 256;
    localparam int GAM_LEVEL_W       = 8;
    localparam int GAM_THR_W         = GAM_FRAC_BITS_MAX + 1;
    localparam int GAM_BIG_W         = 192;

    localparam int LIN_W   = 32;
    localparam int EXP_W   = 32;
    localparam int PROD_W  = LIN_W - 1 + EXP_W;
    localparam int NUM_CH  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPOSURE   = 1'b0,
        CFG_BYTE_ORDER = 1'b1
    } t_cfg_idx;

    typedef logic [GAM_LEVELS-1:0][GAM_THR_W-1:0] t_thr_tab;
    typedef logic [GAM_BIG_W-1:0]                 t_big;

    // smallest fraction f with k^11 * 2^(5g) <= f^5 * 255^11, for every level k
    function automatic t_thr_tab gam_build_table(input int g);
        t_thr_tab             tab;
        t_big                 lhs;
        t_big                 rhs;
        logic [GAM_THR_W-1:0] lo;
        logic [GAM_THR_W-1:0] hi;
        logic [GAM_THR_W-1:0] mid;
        logic [GAM_THR_W:0]   sum;
        for (int k = 0; k < GAM_LEVELS; k++) begin
            lhs = t_big'(1);
            for (int i = 0; i < 11; i++) begin
                lhs = lhs * t_big'(k);
            end
            lhs = lhs << (5 * g);
            lo  = '0;
            hi  = GAM_THR_W'(1) << g;
            for (int it = 0; it <= GAM_THR_W; it++) begin
                if (lo < hi) begin
                    sum = {1'b0, lo} + {1'b0, hi};
                    mid = sum[GAM_THR_W:1];
                    rhs = t_big'(1);
                    for (int i = 0; i < 5; i++) begin
                        rhs = rhs * t_big'(mid);
                    end
                    for (int i = 0; i < 11; i++) begin
                        rhs = rhs * t_big'(255);
                    end
                    if (rhs >= lhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + GAM_THR_W'(1);
                    end
                end
            end
            tab[k] = lo;
        end
        return tab;
    endfunction

endpackage

@@ sv/hdr_pixel_gamma_encode.sv @@
// Exposure and gamma 2.2 encode of one linear RGB pixel (signed Q16.16 per channel) to
// three 8-bit bytes in R,G,B or B,G,R memory order. One pixel is taken every clock
// unless back-pressure from the output fills the pipeline: the pixel lands in an input
// register, moves to a register behind the three 31x32 exposure multipliers, and then to
// the result register. Each stage advances on its own, so a waiting result does not
// block new pixels while a bubble is free ahead of it. With exposure zero each channel
// is clamped to 0..255 and truncated; otherwise the product fraction is encoded through
// a threshold table built at elaboration and searched one bit per step. Negative
// channels give 0. Write exposure and byte order only while the pipeline is empty.
module hdr_pixel_gamma_encode #(
    parameter int GAMMA_FRAC_BITS = hpg_pkg::GAM_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [hpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input pixel stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [95:0]                     i_s_axis_tdata,  // red_linear, green_linear, blue_linear
    // output byte stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata   // byte_first, byte_second, byte_third
);
    import hpg_pkg::*;

    localparam t_thr_tab THR = gam_build_table(GAMMA_FRAC_BITS);

    logic [EXP_W-1:0] r_exposure;
    logic             r_byte_order;

    logic                    r_s1_valid;
    logic [LIN_W-1:0]        r_s1_lin [NUM_CH];
    logic                    r_s2_valid;
    logic [PROD_W-1:0]       r_s2_prod [NUM_CH];
    logic [GAM_LEVEL_W-1:0]  r_s2_raw [NUM_CH];
    logic                    r_s2_neg [NUM_CH];
    logic                    r_out_valid;
    logic [23:0]             r_out_data;

    logic                    s1_en;
    logic                    s2_en;
    logic                    out_en;
    logic [PROD_W-1:0]       n_s2_prod [NUM_CH];
    logic [GAM_LEVEL_W-1:0]  n_s2_raw [NUM_CH];
    logic                    n_s2_neg [NUM_CH];
    logic [GAM_LEVEL_W-1:0]  ch_byte [NUM_CH];
    logic [23:0]             n_out_data;

    assign out_en = !r_out_valid || i_m_axis_tready;
    assign s2_en  = !r_s2_valid || out_en;
    assign s1_en  = !r_s1_valid || s2_en;

    assign o_s_axis_tready = s1_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure   <= '0;
            r_byte_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXPOSURE:   r_exposure   <= i_cfg_data[EXP_W-1:0];
                CFG_BYTE_ORDER: r_byte_order <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // stage 2: sign, raw clamp and exposure product
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_s2_neg[c]  = r_s1_lin[c][LIN_W-1];
            n_s2_prod[c] = PROD_W'(r_s1_lin[c][LIN_W-2:0]) * PROD_W'(r_exposure);
            if (r_s1_lin[c][LIN_W-2:16] >= 15'd255) begin
                n_s2_raw[c] = 8'hff;
            end else begin
                n_s2_raw[c] = r_s1_lin[c][23:16];
            end
        end
    end

    // stage 3: gamma level by binary search over the threshold table, byte select and byte order
    always_comb begin
        logic [GAM_LEVEL_W-1:0]     lo;
        logic [GAM_LEVEL_W-1:0]     cand;
        logic [GAMMA_FRAC_BITS:0]   frac;
        for (int c = 0; c < NUM_CH; c++) begin
            frac = {1'b0, r_s2_prod[c][EXP_W-1 -: GAMMA_FRAC_BITS]};
            lo   = '0;
            for (int b = GAM_LEVEL_W - 1; b >= 0; b--) begin
                cand = lo | (GAM_LEVEL_W'(1) << b);
                if (frac >= THR[cand][GAMMA_FRAC_BITS:0]) begin
                    lo = cand;
                end
            end
            priority if (r_s2_neg[c]) begin
                ch_byte[c] = '0;
            end else if (r_exposure == '0) begin
                ch_byte[c] = r_s2_raw[c];
            end else if (r_s2_prod[c][PROD_W-1:EXP_W] != '0) begin
                ch_byte[c] = 8'hff;
            end else begin
                ch_byte[c] = lo;
            end
        end
        if (r_byte_order) begin
            n_out_data = {ch_byte[0], ch_byte[1], ch_byte[2]};
        end else begin
            n_out_data = {ch_byte[2], ch_byte[1], ch_byte[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_en) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_s_axis_tvalid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_s1_lin[c] <= i_s_axis_tdata[c*LIN_W +: LIN_W];
            end
        end
        if (s2_en && r_s1_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_s2_prod[c] <= n_s2_prod[c];
                r_s2_raw[c]  <= n_s2_raw[c];
                r_s2_neg[c]  <= n_s2_neg[c];
            end
        end
        if (out_en && r_s2_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ tb/hpg_pixel_checker.sv @@
module hpg_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [hpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [95:0]                    i_s_tdata,  // red_linear, green_linear, blue_linear
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [23:0]                    i_m_tdata,  // byte_first, byte_second, byte_third
    output int                             o_fail_count,
    output int                             o_pending
);
    import hpg_pkg::*;

    localparam int FRAC_G = GAM_FRAC_BITS_DEF;

    typedef struct packed {
        logic [7:0] third;
        logic [7:0] second;
        logic [7:0] first;
    } t_rgb_bytes;

    logic [EXP_W-1:0] exposure_q = '0;
    logic             bgr_order_q = 1'b0;
    t_rgb_bytes       due_bytes[$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    // largest level k with k^11 * 2^(5g) <= frac^5 * 255^11
    function automatic logic [7:0] gamma_level(input logic [15:0] frac);
        logic [191:0] frac_side;
        logic [191:0] level_side;
        int           lo;
        int           hi;
        int           mid;
        frac_side = 192'd1;
        for (int i = 0; i < 5; i++) frac_side = frac_side * 192'(frac);
        for (int i = 0; i < 11; i++) frac_side = frac_side * 192'd255;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            level_side = 192'd1;
            for (int i = 0; i < 11; i++) level_side = level_side * 192'(mid);
            level_side = level_side << (5 * FRAC_G);
            if (level_side <= frac_side) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    function automatic logic [7:0] encode_level(input logic [31:0] lin);
        logic [63:0] prod;
        if (lin[31]) return 8'd0;
        if (exposure_q == '0) begin
            return (lin[30:16] >= 15'd255) ? 8'd255 : lin[23:16];
        end
        prod = {33'b0, lin[30:0]} * {32'b0, exposure_q};
        if (prod[63:32] != '0) return 8'd255;
        return gamma_level(16'(prod[31:0] >> (32 - FRAC_G)));
    endfunction

    function automatic t_rgb_bytes encode_pixel(input logic [95:0] lin);
        t_rgb_bytes  px;
        logic [7:0]  red;
        logic [7:0]  blue;
        red       = encode_level(lin[31:0]);
        px.second = encode_level(lin[63:32]);
        blue      = encode_level(lin[95:64]);
        px.first  = bgr_order_q ? blue : red;
        px.third  = bgr_order_q ? red : blue;
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_rgb_bytes want;
        t_rgb_bytes got;
        if (!i_rst_n) begin
            exposure_q  = '0;
            bgr_order_q = 1'b0;
            due_bytes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_EXPOSURE:   exposure_q  = i_cfg_data;
                    CFG_BYTE_ORDER: bgr_order_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (due_bytes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output item %h", got);
                end else begin
                    want = due_bytes.pop_front();
                    if (got.first !== want.first || got.second !== want.second ||
                        got.third !== want.third) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("byte mismatch: exp %h %h %h got %h %h %h",
                                     want.first, want.second, want.third,
                                     got.first, got.second, got.third);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) due_bytes.push_back(encode_pixel(i_s_tdata));
        end
        o_pending = due_bytes.size();
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import hpg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;

    // receiver stall control
    int                    rx_mode = 0;
    int                    rx_mode_left = 0;
    int                    rx_hold_left = 0;
    bit                    long_hold_req = 1'b0;
    bit                    long_hold_done = 1'b0;

    hdr_pixel_gamma_encode DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    hpg_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rx_hold_left = 120;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 599) == 0) begin
            rx_hold_left = $urandom_range(20, 60);
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(30, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_mode_left % 5) != 0);
            endcase
        end
    end

    function automatic logic [31:0] rand_channel(input logic [31:0] gain);
        logic [63:0] span;
        int          pick;
        pick = $urandom_range(0, 7);
        // largest magnitude whose product stays below 1.0, or 255.0 itself in clamp mode
        if (gain == '0) span = 64'h00FF_0000;
        else span = 64'hFFFF_FFFF / {32'b0, gain};
        case (pick)
            0, 1: return $urandom;
            2:    return $urandom_range(0, 32'h0000_FFFF);
            3:    return 32'h8000_0000 | $urandom;
            4: begin
                if (span > 64'h7FFF_FFFF) return $urandom & 32'h7FFF_FFFF;
                return span[31:0] + $urandom_range(0, 2) - 32'd1;
            end
            default: begin
                if (span > 64'h7FFF_FFFF) return $urandom & 32'h7FFF_FFFF;
                return $urandom_range(0, span[31:0]);
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [31:0] red, input logic [31:0] green,
                              input logic [31:0] blue);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input logic [31:0] gain, input logic bgr);
        settle();
        write_reg(CFG_EXPOSURE, gain);
        write_reg(CFG_BYTE_ORDER, {31'b0, bgr});
    endtask

    task automatic run_random(input int count, input logic [31:0] gain, input bit squeeze);
        int burst;
        burst = $urandom_range(1, 30);
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == 0) begin
                long_hold_req = 1'b1;
                burst = 40;
            end
            if (squeeze && n == count / 2) settle();
            send_pixel(rand_channel(gain), rand_channel(gain), rand_channel(gain));
            if ($urandom_range(0, 149) == 0) settle();
            burst--;
            if (burst == 0) begin
                idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        logic [31:0] gains[10];
        logic [31:0] gain;
        gains = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h0000_4000, 32'h0010_0000, 32'h0000_0000, 32'h0002_8000,
                  32'h0000_0000, 32'h0000_0000};
        gains[8] = $urandom;
        gains[9] = $urandom_range(1, 32'h0004_0000);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // clamp mode: zero, saturation, negatives, the 255.0 boundary
        set_mode(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(32'hFFFF_FFFF, 32'h00FF_0000, 32'h00FE_FFFF);
        send_pixel(32'h0001_0000, 32'h0000_FFFF, 32'h00FF_8000);
        send_pixel(32'h0080_0000, 32'h0000_0001, 32'h4000_0000);

        // unity gain, swapped order: product exactly 1.0, just below, tiny
        set_mode(32'h0001_0000, 1'b1);
        send_pixel(32'h0001_0000, 32'h0000_FFFF, 32'h0000_0001);
        send_pixel(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0010);

        // largest gain: products just under and above 1.0
        set_mode(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0001, 32'h0000_0002, 32'h0000_0000);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0000);

        // smallest gain: some fractions cut to zero
        set_mode(32'h0000_0001, 1'b1);
        send_pixel(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0001);
        send_pixel(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);

        for (int p = 0; p < 10; p++) begin
            gain = gains[p];
            set_mode(gain, 1'(p % 2));
            run_random(110, gain, p == 1);
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ hdr_pixel_gamma_encode.f @@
sv/hpg_pkg.sv
sv/hdr_pixel_gamma_encode.sv
tb/hpg_pixel_checker.sv
tb/tb.sv
